/* rtl/core/kvst_pkg.sv */
// kvst_pkg: sizes, widths and command codes for the key-value set table.
// No dependencies; imported by key_value_set_table.
`default_nettype none

package kvst_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/key_value_set_table.sv */
// key_value_set_table: one bucket of a key-value set held in an entry memory
// with one read and one write port and per-entry valid flags. Depends on kvst_pkg.
//
// Input channel (in_valid/in_stall) carries cmd, key and value_in; output
// channel (out_valid/out_stall) carries success, full_res and value_out, one
// result transaction per input transaction, in order.
// Insert adds the pair only if the key is absent (full_res when all CAPACITY
// entries are in use), delete removes it and returns the value, find returns
// the value; an unused command gives an all-zero result and changes nothing.
// Each request scans the entry memory one address per cycle through its single
// read port, stopping early when the key is found, and its result is loaded
// into the output register once that register is free. One request is in work at a
// time: in_stall is high from acceptance until the result is loaded, so the
// table cannot take a new request before it is through with the last one.
// The output register holds a result while out_stall is high; the next request
// can be accepted and scanned meanwhile, and only its completion waits for the
// output register to free up.
// Reset (rst, synchronous) clears all valid flags, the entry count and both
// channels' control state; no clearing pass is needed.
`default_nettype none

module key_value_set_table
  import kvst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [VAL_W-1:0] value_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  success,
  output logic                  full_res,
  output logic [VAL_W-1:0]      value_out
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;

  logic [CAPACITY-1:0] entry_valid;
  logic [CNT_W-1:0]    entry_count;

  logic [IDX_W-1:0]    rd_addr;
  logic                issue_en;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx;
  logic                cmp_valid;
  entry_t              rd_data;

  logic                hit_found;
  logic [IDX_W-1:0]    hit_idx;
  logic [VAL_W-1:0]    hit_val;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  entry_t              mem [CAPACITY];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  logic                match;
  logic                cmp_last;
  logic                out_free;
  logic                table_full;

  assign match      = cmp_vld && cmp_valid && (rd_data.key == key_q);
  assign cmp_last   = cmp_vld && (cmp_idx == IDX_W'(CAPACITY - 1));
  assign out_free   = !out_valid || !out_stall;
  assign table_full = (entry_count == CNT_W'(CAPACITY));
  assign in_stall   = (state != S_IDLE);

  assign mem_we    = (state == S_DONE) && out_free && (cmd_q == CMD_INSERT) &&
                     !hit_found && !table_full;
  assign mem_waddr = free_idx;
  assign mem_wdata = '{key: key_q, value: val_q};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      entry_count <= '0;
      issue_en    <= 1'b0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            key_q      <= key;
            val_q      <= value_in;
            rd_addr    <= '0;
            issue_en   <= 1'b1;
            cmp_vld    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= issue_en && !(match || cmp_last);
          if (issue_en) begin
            cmp_idx   <= rd_addr;
            cmp_valid <= entry_valid[rd_addr];
            if (!entry_valid[rd_addr] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_addr;
            end
            rd_addr <= rd_addr + 1'b1;
          end
          if (match || cmp_last ||
              (issue_en && (rd_addr == IDX_W'(CAPACITY - 1)))) begin
            issue_en <= 1'b0;
          end
          if (match) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_val   <= rd_data.value;
          end
          if (match || cmp_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            unique case (cmd_q)
              CMD_INSERT: begin
                success   <= !hit_found && !table_full;
                full_res  <= !hit_found && table_full;
                value_out <= '0;
                if (!hit_found && !table_full) begin
                  entry_valid[free_idx] <= 1'b1;
                  entry_count           <= entry_count + 1'b1;
                end
              end
              CMD_DELETE: begin
                success   <= hit_found;
                full_res  <= 1'b0;
                value_out <= hit_found ? hit_val : '0;
                if (hit_found) begin
                  entry_valid[hit_idx] <= 1'b0;
                  entry_count          <= entry_count - 1'b1;
                end
              end
              CMD_FIND: begin
                success   <= hit_found;
                full_res  <= 1'b0;
                value_out <= hit_found ? hit_val : '0;
              end
              default: begin
                success   <= 1'b0;
                full_res  <= 1'b0;
                value_out <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
